// ===== rtl/core/gsa_pkg.sv =====
package gsa_pkg;

  localparam int MAX_N   = 64;
  localparam int IDX_W   = $clog2(MAX_N);
  localparam int CNT_W   = IDX_W + 1;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_N * MAX_N;
  localparam int DATA_W  = 32;
  localparam int SCALE_W = 18;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int ACC_W   = PROD_W + IDX_W;
  localparam int LO_W    = (ACC_W + 1) / 2;
  localparam int HI_W    = ACC_W - LO_W;

  localparam logic [CNT_W-1:0]          SIZE_RST  = CNT_W'(MAX_N);
  localparam logic signed [SCALE_W-1:0] ALPHA_RST = 18'sd72090;
  localparam logic signed [SCALE_W-1:0] BETA_RST  = 18'sd58982;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_LOAD_C  = 2'd2,
    OP_COMPUTE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_SIZE  = 2'd0,
    CFG_ALPHA = 2'd1,
    CFG_BETA  = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  // one A element travelling down the cell chain
  typedef struct packed {
    logic                     v;
    logic                     first;
    logic [IDX_W-1:0]         k;
    logic signed [DATA_W-1:0] a;
  } feed_t;

  // one finished dot product leaving cell 0
  typedef struct packed {
    logic                    v;
    logic                    last;
    logic [IDX_W-1:0]        col;
    logic signed [ACC_W-1:0] sum;
  } drain_t;

  // C write-back of a finished element
  typedef struct packed {
    logic                     we;
    logic                     last;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] data;
  } wb_t;

endpackage

// ===== rtl/core/gsa_cell.sv =====
// One column of the product: holds column j of B, multiplies the passing A
// element and accumulates exactly. Drain shifts sums toward cell 0.
module gsa_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              b_we,
  input  logic [gsa_pkg::IDX_W-1:0]         b_addr,
  input  logic signed [gsa_pkg::DATA_W-1:0] b_data,
  input  gsa_pkg::feed_t                    fin,
  output gsa_pkg::feed_t                    fout,
  input  logic                              drain,
  input  logic signed [gsa_pkg::ACC_W-1:0]  acc_in,
  output logic signed [gsa_pkg::ACC_W-1:0]  acc_out
);

  logic signed [gsa_pkg::DATA_W-1:0] bmem [gsa_pkg::MAX_N];
  logic signed [gsa_pkg::DATA_W-1:0] b_q_r;
  logic                              fv_r;
  logic                              ffirst_r;
  logic [gsa_pkg::IDX_W-1:0]         fk_r;
  logic signed [gsa_pkg::DATA_W-1:0] fa_r;
  logic signed [gsa_pkg::PROD_W-1:0] prod_r;
  logic                              pv_r;
  logic                              pfirst_r;
  logic signed [gsa_pkg::ACC_W-1:0]  acc_r;
  logic signed [gsa_pkg::ACC_W-1:0]  acc_nxt;

  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[b_addr] <= b_data;
    end
    b_q_r <= bmem[fin.k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      fv_r <= fin.v;
      pv_r <= fv_r;
    end
  end

  always_ff @(posedge clk) begin
    ffirst_r <= fin.first;
    fk_r     <= fin.k;
    fa_r     <= fin.a;
    pfirst_r <= ffirst_r;
    prod_r   <= fa_r * b_q_r;
    acc_r    <= acc_nxt;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (drain) begin
      acc_nxt = acc_in;
    end else if (pv_r) begin
      if (pfirst_r) begin
        acc_nxt = gsa_pkg::ACC_W'(prod_r);
      end else begin
        acc_nxt = acc_r + gsa_pkg::ACC_W'(prod_r);
      end
    end
  end

  assign fout    = '{v: fv_r, first: ffirst_r, k: fk_r, a: fa_r};
  assign acc_out = acc_r;

endmodule

// ===== rtl/core/gsa_post.sv =====
// Scale and round: alpha*sum and beta*c, each half-up to Q16.16, then
// add and saturate. Four register stages, one column per cycle.
module gsa_post (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gsa_pkg::drain_t                    din,
  input  logic [gsa_pkg::IDX_W-1:0]          row,
  input  logic signed [gsa_pkg::DATA_W-1:0]  c_rdata,
  input  logic signed [gsa_pkg::SCALE_W-1:0] alpha,
  input  logic signed [gsa_pkg::SCALE_W-1:0] beta,
  output logic                               out_valid,
  output logic [gsa_pkg::IDX_W-1:0]          out_row,
  output logic [gsa_pkg::IDX_W-1:0]          out_col,
  output logic signed [gsa_pkg::DATA_W-1:0]  out_result,
  output logic                               out_last,
  output gsa_pkg::wb_t                       wb
);

  localparam int PLO_W = gsa_pkg::SCALE_W + gsa_pkg::LO_W + 1;
  localparam int PHI_W = gsa_pkg::SCALE_W + gsa_pkg::HI_W;
  localparam int PB_W  = gsa_pkg::SCALE_W + gsa_pkg::DATA_W;
  localparam int M_W   = PHI_W + gsa_pkg::LO_W;
  localparam int QA_W  = M_W - gsa_pkg::DATA_W;
  localparam int QB_W  = PB_W - 16;
  localparam int T_W   = QA_W + 1;

  logic                             s0_v_r, s0_last_r;
  logic [gsa_pkg::IDX_W-1:0]        s0_col_r;
  logic signed [gsa_pkg::ACC_W-1:0] s0_sum_r;

  logic                             p_v_r, p_last_r;
  logic [gsa_pkg::IDX_W-1:0]        p_col_r;
  logic signed [PLO_W-1:0]          plo_r, plo_nxt;
  logic signed [PHI_W-1:0]          phi_r, phi_nxt;
  logic signed [PB_W-1:0]           pb_r, pb_nxt;

  logic                             q_v_r, q_last_r;
  logic [gsa_pkg::IDX_W-1:0]        q_col_r;
  logic signed [QA_W-1:0]           qa_r;
  logic signed [QB_W-1:0]           qb_r;
  logic signed [M_W-1:0]            m;
  logic signed [PB_W-1:0]           pb_rnd;

  logic signed [T_W-1:0]            t;
  logic signed [gsa_pkg::DATA_W-1:0] sat;

  always_comb begin
    plo_nxt = alpha * $signed({1'b0, s0_sum_r[gsa_pkg::LO_W-1:0]});
    phi_nxt = alpha * $signed(s0_sum_r[gsa_pkg::ACC_W-1:gsa_pkg::LO_W]);
    pb_nxt  = beta * c_rdata;
  end

  always_comb begin
    m      = (M_W'(phi_r) <<< gsa_pkg::LO_W) + M_W'(plo_r) + (M_W'(1) <<< 31);
    pb_rnd = pb_r + (PB_W'(1) <<< 15);
  end

  always_comb begin
    t = T_W'(qa_r) + T_W'(qb_r);
    if (t > T_W'(32'sh7fffffff)) begin
      sat = 32'sh7fffffff;
    end else if (t < -(T_W'(1) <<< 31)) begin
      sat = 32'sh80000000;
    end else begin
      sat = t[gsa_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r    <= 1'b0;
      p_v_r     <= 1'b0;
      q_v_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s0_v_r    <= din.v;
      p_v_r     <= s0_v_r;
      q_v_r     <= p_v_r;
      out_valid <= q_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_last_r  <= din.last;
    s0_col_r   <= din.col;
    s0_sum_r   <= din.sum;
    p_last_r   <= s0_last_r;
    p_col_r    <= s0_col_r;
    plo_r      <= plo_nxt;
    phi_r      <= phi_nxt;
    pb_r       <= pb_nxt;
    q_last_r   <= p_last_r;
    q_col_r    <= p_col_r;
    qa_r       <= m[M_W-1:gsa_pkg::DATA_W];
    qb_r       <= pb_rnd[PB_W-1:16];
    out_row    <= row;
    out_col    <= q_col_r;
    out_result <= sat;
    out_last   <= q_last_r;
  end

  assign wb = '{we: q_v_r, last: q_last_r, row: row, col: q_col_r, data: sat};

endmodule

// ===== rtl/core/gemm_scaled_accumulate.sv =====
// Channel   Direction  Handshake            Payload
// input     in         start / busy         in_op, in_row, in_col, in_value
// result    out        out_valid strobe     out_row, out_col, out_result, out_last
// config    in         cfg_we (no wait)     cfg_index, cfg_data
//
// Load transaction: busy stays low.
// Compute transaction: a feed phase passing A[r][*] down the
// chain, a wait for the chain to settle, a drain phase, then 4 post stages.
// The cell chain length and the single drain path set its length.
// Reset (rst_n low, synchronous) restores size 64, alpha 1.1, beta 0.9;
// A, B and C contents stay undefined until written.
// Results appear one per cycle in column order; the receiver cannot stall.
module gemm_scaled_accumulate (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_op,
  input  logic [gsa_pkg::IDX_W-1:0]           in_row,
  input  logic [gsa_pkg::IDX_W-1:0]           in_col,
  input  logic signed [gsa_pkg::DATA_W-1:0]   in_value,
  output logic                                out_valid,
  output logic [gsa_pkg::IDX_W-1:0]           out_row,
  output logic [gsa_pkg::IDX_W-1:0]           out_col,
  output logic signed [gsa_pkg::DATA_W-1:0]   out_result,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [gsa_pkg::SCALE_W-1:0]         cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FEED  = 5'b00010,
    S_WAIT  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [gsa_pkg::CNT_W-1:0]          size_r;
  logic signed [gsa_pkg::SCALE_W-1:0] alpha_r, beta_r;
  logic [gsa_pkg::CNT_W-1:0]          n_eff;

  logic [gsa_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [gsa_pkg::IDX_W-1:0]          row_r, row_nxt;

  logic accept, in_range, load_a, load_b, load_c, go;
  logic cnt_end_n, cnt_end_wait;

  // stores
  logic signed [gsa_pkg::DATA_W-1:0] amem [gsa_pkg::DEPTH];
  logic signed [gsa_pkg::DATA_W-1:0] cmem [gsa_pkg::DEPTH];
  logic signed [gsa_pkg::DATA_W-1:0] a_q_r, c_q_r;
  logic [gsa_pkg::ADDR_W-1:0]        rd_addr, c_waddr, ld_addr;
  logic                              c_we;
  logic signed [gsa_pkg::DATA_W-1:0] c_wdata;

  // chain
  logic                              f0_v_r, f0_first_r;
  logic [gsa_pkg::IDX_W-1:0]         f0_k_r;
  gsa_pkg::feed_t                    feed_link [gsa_pkg::MAX_N+1];
  logic signed [gsa_pkg::ACC_W-1:0]  acc_link  [gsa_pkg::MAX_N+1];
  logic                              drain;
  gsa_pkg::drain_t                   din;
  gsa_pkg::wb_t                      wb;

  // effective size: zero reads as 1, above MAX_N as MAX_N
  always_comb begin
    n_eff = size_r;
    if (size_r == '0) begin
      n_eff = gsa_pkg::CNT_W'(1);
    end else if (size_r > gsa_pkg::SIZE_RST) begin
      n_eff = gsa_pkg::SIZE_RST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= gsa_pkg::SIZE_RST;
      alpha_r <= gsa_pkg::ALPHA_RST;
      beta_r  <= gsa_pkg::BETA_RST;
    end else if (cfg_we) begin
      unique case (gsa_pkg::cfg_idx_t'(cfg_index))
        gsa_pkg::CFG_SIZE:  size_r  <= cfg_data[gsa_pkg::CNT_W-1:0];
        gsa_pkg::CFG_ALPHA: alpha_r <= $signed(cfg_data);
        gsa_pkg::CFG_BETA:  beta_r  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = ({1'b0, in_row} < n_eff) && ({1'b0, in_col} < n_eff);
  assign load_a   = accept && (in_op == gsa_pkg::OP_LOAD_A) && in_range;
  assign load_b   = accept && (in_op == gsa_pkg::OP_LOAD_B) && in_range;
  assign load_c   = accept && (in_op == gsa_pkg::OP_LOAD_C) && in_range;
  assign go       = accept && (in_op == gsa_pkg::OP_COMPUTE) && ({1'b0, in_row} < n_eff);

  assign cnt_end_n    = (cnt_r == n_eff - gsa_pkg::CNT_W'(1));
  assign cnt_end_wait = (cnt_r == n_eff + gsa_pkg::CNT_W'(5));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          state_nxt = S_FEED;
          cnt_nxt   = '0;
          row_nxt   = in_row;
        end
      end
      S_FEED: begin
        cnt_nxt = cnt_r + gsa_pkg::CNT_W'(1);
        if (cnt_end_n) begin
          state_nxt = S_WAIT;
          cnt_nxt   = '0;
        end
      end
      S_WAIT: begin
        cnt_nxt = cnt_r + gsa_pkg::CNT_W'(1);
        if (cnt_end_wait) begin
          state_nxt = S_DRAIN;
          cnt_nxt   = '0;
        end
      end
      S_DRAIN: begin
        cnt_nxt = cnt_r + gsa_pkg::CNT_W'(1);
        if (cnt_end_n) begin
          state_nxt = S_FLUSH;
          cnt_nxt   = '0;
        end
      end
      S_FLUSH: begin
        if (wb.we && wb.last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      f0_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      f0_v_r  <= (state_r == S_FEED);
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    f0_first_r <= (cnt_r == '0);
    f0_k_r     <= cnt_r[gsa_pkg::IDX_W-1:0];
  end

  // A and C stores: one write port, one registered read port each
  assign ld_addr = {in_row, in_col};
  assign rd_addr = {row_r, cnt_r[gsa_pkg::IDX_W-1:0]};
  assign c_we    = load_c || wb.we;
  assign c_waddr = wb.we ? {wb.row, wb.col} : ld_addr;
  assign c_wdata = wb.we ? wb.data : in_value;

  always_ff @(posedge clk) begin
    if (load_a) begin
      amem[ld_addr] <= in_value;
    end
    a_q_r <= amem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    c_q_r <= cmem[rd_addr];
  end

  // cell chain: A enters at cell 0, sums drain back out of cell 0
  assign feed_link[0]             = '{v: f0_v_r, first: f0_first_r, k: f0_k_r, a: a_q_r};
  assign acc_link[gsa_pkg::MAX_N] = '0;
  assign drain                    = (state_r == S_DRAIN);

  for (genvar j = 0; j < gsa_pkg::MAX_N; j++) begin : g_cell
    gsa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .b_we    (load_b && (in_col == gsa_pkg::IDX_W'(j))),
      .b_addr  (in_row),
      .b_data  (in_value),
      .fin     (feed_link[j]),
      .fout    (feed_link[j+1]),
      .drain   (drain),
      .acc_in  (acc_link[j+1]),
      .acc_out (acc_link[j])
    );
  end

  assign din = '{v: drain, last: cnt_end_n, col: cnt_r[gsa_pkg::IDX_W-1:0], sum: acc_link[0]};

  gsa_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .din        (din),
    .row        (row_r),
    .c_rdata    (c_q_r),
    .alpha      (alpha_r),
    .beta       (beta_r),
    .out_valid  (out_valid),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_result (out_result),
    .out_last   (out_last),
    .wb         (wb)
  );

  // a compute on a row in range always starts the sequencer
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> busy)
    else $error("compute transaction did not start");

  // results within a row come on consecutive cycles, column by column
  a_col_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && (out_col == $past(out_col) + 1'b1))
    else $error("result columns not consecutive");

  // write-back only happens in the drain or flush state, never while idle
  a_wb_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wb.we |-> (state_r == S_DRAIN) || (state_r == S_FLUSH))
    else $error("write-back outside a compute");

  // the drain path never runs while feeding
  a_drain_excl: assert property (@(posedge clk) disable iff (!rst_n)
    f0_v_r |-> !drain)
    else $error("drain overlaps feed");

endmodule
